[src/pidh_pkg.sv]
// ----------------------------------------------------------------------------
// pidh_pkg
// Shared types, codes and constants of the heater PID controller.
// ----------------------------------------------------------------------------
package pidh_pkg;

  localparam int TEMP_FRAC_BITS = 4;
  localparam int ACC_W          = 48;
  localparam int K_SHIFT        = 16 - TEMP_FRAC_BITS;
  localparam int SUM_W          = 43;

  localparam logic [1:0] CMD_COMPUTE  = 2'd0;
  localparam logic [1:0] CMD_RESET    = 2'd1;
  localparam logic [1:0] CMD_BUMPLESS = 2'd2;

  localparam logic [2:0] STAT_NORMAL = 3'd0;
  localparam logic [2:0] STAT_HIGH   = 3'd1;
  localparam logic [2:0] STAT_LOW    = 3'd2;
  localparam logic [2:0] STAT_REJECT = 3'd3;
  localparam logic [2:0] STAT_RESET  = 3'd4;

  localparam logic [2:0] REG_GAIN_P   = 3'd0;
  localparam logic [2:0] REG_GAIN_I   = 3'd1;
  localparam logic [2:0] REG_GAIN_D   = 3'd2;
  localparam logic [2:0] REG_LIMITS   = 3'd3;
  localparam logic [2:0] REG_MODE     = 3'd4;
  localparam logic [2:0] REG_FF_PTS   = 3'd5;
  localparam logic [2:0] REG_BANDS    = 3'd6;
  localparam logic [2:0] REG_FACTORS  = 3'd7;

  localparam int MODE_ADAPT = 0;
  localparam int MODE_FF    = 1;

  // dividend widths of the serial divide steps
  localparam logic [6:0] W_PCT  = 7'd23;
  localparam logic [6:0] W_PD   = 7'd38;
  localparam logic [6:0] W_I    = 7'd63;
  localparam logic [6:0] W_FF   = 7'd39;
  localparam logic [6:0] W_SEED = 7'd36;

  localparam logic [23:0] DIV_PCT   = 24'd100;
  localparam logic [23:0] DIV_MILLI = 24'd1000;
  localparam logic [23:0] DIV_I     = 24'd15625;
  localparam logic [23:0] MUL_SEED  = 24'd1000000;
  localparam logic [40:0] I_CAP     = 41'd1 << 40;

  typedef enum logic [4:0] {
    S_IDLE, S_LO, S_BASE, S_PMUL, S_PDIV, S_DMUL, S_DDIV, S_TMUL, S_IMUL, S_IDIV,
    S_FFLAT, S_FMUL1, S_FMUL2, S_FDIV, S_CMUL, S_CDIV, S_SMUL, S_SDIV, S_FIN
  } pidh_state_t;

  typedef struct packed {
    logic       start;
    logic       is_div;
    logic [6:0] steps;
  } pidh_op_t;

  function automatic logic [6:0] pct_clip(input logic [7:0] p);
    logic [6:0] r;
    r = (p > 8'd100) ? 7'd100 : p[6:0];
    return r;
  endfunction

endpackage

[src/pidh_serial.sv]
// ----------------------------------------------------------------------------
// pidh_serial
// Bit-serial arithmetic unit: shift-add multiply and restoring divide.
// ----------------------------------------------------------------------------
module pidh_serial import pidh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  pidh_op_t    op,
  input  logic [63:0] opa,
  input  logic [23:0] opb,
  output logic        done,
  output logic [63:0] res
);

  logic        busy_r, busy_nxt, div_r, div_nxt, done_r, done_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] acc_r, acc_nxt, mcand_r, mcand_nxt;
  logic [23:0] mpl_r, mpl_nxt, dsor_r, dsor_nxt, rem_r, rem_nxt;
  logic [24:0] trial;

  always_comb begin
    busy_nxt  = busy_r;
    div_nxt   = div_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    mpl_nxt   = mpl_r;
    dsor_nxt  = dsor_r;
    rem_nxt   = rem_r;
    trial     = {rem_r, acc_r[63]};
    if (op.start) begin
      busy_nxt  = 1'b1;
      div_nxt   = op.is_div;
      cnt_nxt   = op.steps;
      dsor_nxt  = opb;
      mpl_nxt   = opb;
      rem_nxt   = '0;
      acc_nxt   = op.is_div ? opa : 64'd0;
      mcand_nxt = opa;
    end else if (busy_r) begin
      if (div_r) begin
        if (cnt_r == 7'd0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          if (trial >= {1'b0, dsor_r}) begin
            rem_nxt = 24'(trial - {1'b0, dsor_r});
            acc_nxt = {acc_r[62:0], 1'b1};
          end else begin
            rem_nxt = trial[23:0];
            acc_nxt = {acc_r[62:0], 1'b0};
          end
          cnt_nxt = cnt_r - 7'd1;
        end
      end else begin
        if (mpl_r == 24'd0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          if (mpl_r[0]) acc_nxt = acc_r + mcand_r;
          mcand_nxt = {mcand_r[62:0], 1'b0};
          mpl_nxt   = {1'b0, mpl_r[23:1]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r   <= div_nxt;
    cnt_r   <= cnt_nxt;
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    mpl_r   <= mpl_nxt;
    dsor_r  <= dsor_nxt;
    rem_r   <= rem_nxt;
  end

  assign done = done_r;
  assign res  = acc_r;

endmodule

[src/pid_heater_controller.sv]
// ----------------------------------------------------------------------------
// pid_heater_controller
// Fixed-point heater PID with feedforward, adaptive ceiling and anti-windup.
// ----------------------------------------------------------------------------
// Each compute tick runs its multiplies and divides in turn on the shared
// bit-serial unit (one bit per cycle of each multiply and divide).
// Reset commands and zero ticks go straight to the finish step.
// Throughput: one item at a time; the next is taken once the result is queued.
// Reset: state, history and output valid clear; registers take reset values.
// ----------------------------------------------------------------------------
module pid_heater_controller import pidh_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [15:0] in_setpoint,
  input  logic signed [15:0] in_measured_temp,
  input  logic [15:0]        in_tick_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [16:0]        out_duty,
  output logic [2:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  logic [9:0]  gp_r, gi_r, gd_r;
  logic [15:0] lim_r;
  logic [1:0]  mode_r;
  logic [37:0] ffp_r;
  logic [47:0] band_r;
  logic [27:0] fac_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gp_r   <= '0;
      gi_r   <= '0;
      gd_r   <= '0;
      lim_r  <= 16'd25600;
      mode_r <= '0;
      ffp_r  <= 38'd819300;
      band_r <= 48'd206326284338;
      fac_r  <= 28'd211366500;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN_P:  gp_r   <= cfg_data[9:0];
        REG_GAIN_I:  gi_r   <= cfg_data[9:0];
        REG_GAIN_D:  gd_r   <= cfg_data[9:0];
        REG_LIMITS:  lim_r  <= cfg_data[15:0];
        REG_MODE:    mode_r <= cfg_data[1:0];
        REG_FF_PTS:  ffp_r  <= cfg_data[37:0];
        REG_BANDS:   band_r <= cfg_data[47:0];
        REG_FACTORS: fac_r  <= cfg_data[27:0];
        default: ;
      endcase
    end
  end

  pidh_state_t            state_r, state_nxt;
  logic                   run_r, run_nxt;
  logic [1:0]             cmd_r, cmd_nxt;
  logic [15:0]            sp_r, sp_nxt, m_r, m_nxt, tick_r, tick_nxt;
  logic signed [16:0]     e_r, e_nxt;
  logic [15:0]            abse_r, abse_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [16:0]            lo_r, lo_nxt, base_r, base_nxt, hi_r, hi_nxt, ff_r, ff_nxt;
  logic signed [ACC_W-1:0] tent_r, tent_nxt, acc_r, acc_nxt, seed_r, seed_nxt;
  logic [22:0]            ff2_r, ff2_nxt;
  logic [15:0]            last_r, last_nxt;
  logic                   hist_r, hist_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [16:0]            duty_r, duty_nxt;
  logic [2:0]             status_r, status_nxt;

  pidh_op_t    u_op;
  logic [63:0] u_a, u_res;
  logic [23:0] u_b;
  logic        u_done;

  pidh_serial u_serial (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (u_op),
    .opa   (u_a),
    .opb   (u_b),
    .done  (u_done),
    .res   (u_res)
  );

  // derived operands
  logic [6:0]  lim_min, lim_max, fsel;
  logic [15:0] thr0, thr1, thr2, thr3;
  logic        ceil_go;
  logic [11:0] tl, th;
  logic [6:0]  pl, ph;
  logic [15:0] den, n_cl, absdm;
  logic signed [17:0] n_raw;
  logic [23:0] ff_dsor;
  logic signed [16:0] dm;
  logic        dm_pos;
  logic [ACC_W-1:0] tent_mag;
  pidh_state_t ceil_state, ff_state;

  always_comb begin
    lim_min = pct_clip(lim_r[7:0]);
    lim_max = pct_clip(lim_r[15:8]);
    thr0 = {band_r[11:0], 4'b0};
    thr1 = {band_r[23:12], 4'b0};
    thr2 = {band_r[35:24], 4'b0};
    thr3 = {band_r[47:36], 4'b0};
    if (abse_r >= thr1)      fsel = pct_clip({1'b0, fac_r[6:0]});
    else if (abse_r >= thr2) fsel = pct_clip({1'b0, fac_r[13:7]});
    else if (abse_r >= thr3) fsel = pct_clip({1'b0, fac_r[20:14]});
    else                     fsel = pct_clip({1'b0, fac_r[27:21]});
    ceil_go    = mode_r[MODE_ADAPT] && (abse_r < thr0);
    ceil_state = ceil_go ? S_CMUL : S_FIN;
    tl = ffp_r[11:0];
    th = ffp_r[23:12];
    pl = ffp_r[30:24];
    ph = ffp_r[37:31];
    ff_state = (th > tl) ? S_FMUL1 : S_FFLAT;
    den   = {12'(th - tl), 4'b0};
    n_raw = $signed({{2{sp_r[15]}}, sp_r}) - $signed({2'b0, tl, 4'b0});
    if (n_raw < 0)                         n_cl = '0;
    else if (n_raw > $signed({2'b0, den})) n_cl = den;
    else                                   n_cl = n_raw[15:0];
    ff_dsor = 24'({8'b0, den} * DIV_PCT);
    dm     = $signed({m_r[15], m_r}) - $signed({last_r[15], last_r});
    absdm  = dm[16] ? 16'(-dm) : dm[15:0];
    dm_pos = !dm[16] && (dm != 17'sd0);
    tent_mag = tent_r[ACC_W-1] ? ACC_W'(-tent_r) : ACC_W'(tent_r);
  end

  // result capture helpers
  logic signed [SUM_W-1:0] term_s;
  logic signed [ACC_W+1:0] tsum;
  logic signed [ACC_W+1:0] dlt;
  logic [40:0]  icap;
  logic [16:0]  ffl, hi_use;
  logic         out_free;

  always_comb begin
    state_nxt = state_r;
    run_nxt   = run_r;
    cmd_nxt   = cmd_r;
    sp_nxt    = sp_r;
    m_nxt     = m_r;
    tick_nxt  = tick_r;
    e_nxt     = e_r;
    abse_nxt  = abse_r;
    sum_nxt   = sum_r;
    lo_nxt    = lo_r;
    base_nxt  = base_r;
    hi_nxt    = hi_r;
    ff_nxt    = ff_r;
    ff2_nxt   = ff2_r;
    tent_nxt  = tent_r;
    seed_nxt  = seed_r;
    acc_nxt   = acc_r;
    last_nxt  = last_r;
    hist_nxt  = hist_r;
    duty_nxt  = duty_r;
    status_nxt = status_r;
    out_free  = !out_valid_r || !out_stall;
    out_valid_nxt = out_valid_r && out_stall;
    u_op  = '0;
    u_a   = '0;
    u_b   = '0;
    term_s = '0;
    dlt   = '0;
    tsum  = '0;
    icap  = '0;
    ffl   = u_res[16:0] > base_r ? base_r : u_res[16:0];
    hi_use = ceil_go ? hi_r : base_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt  = in_command;
          sp_nxt   = in_setpoint;
          m_nxt    = in_measured_temp;
          tick_nxt = in_tick_ms;
          e_nxt    = $signed({in_setpoint[15], in_setpoint}) -
                     $signed({in_measured_temp[15], in_measured_temp});
          abse_nxt = e_nxt[16] ? 16'(-e_nxt) : e_nxt[15:0];
          sum_nxt  = '0;
          seed_nxt = '0;
          if (in_command == CMD_COMPUTE && in_tick_ms != 16'd0)
            state_nxt = S_LO;
          else if (in_command == CMD_BUMPLESS && !mode_r[MODE_FF] && gi_r != 10'd0)
            state_nxt = S_BASE;
          else
            state_nxt = S_FIN;
        end
      end
      S_LO, S_BASE: begin
        u_op = '{start: !run_r, is_div: 1'b1, steps: W_PCT};
        u_a  = 64'(state_r == S_LO ? lim_min : lim_max) << 57;
        u_b  = DIV_PCT;
        if (!run_r) run_nxt = 1'b1;
        else if (u_done) begin
          run_nxt = 1'b0;
          if (state_r == S_LO) begin
            lo_nxt = u_res[16:0];
            state_nxt = S_BASE;
          end else begin
            base_nxt = u_res[16:0];
            state_nxt = (cmd_r == CMD_COMPUTE) ? S_PMUL : ff_state;
          end
        end
      end
      S_PMUL, S_DMUL, S_TMUL, S_IMUL, S_FMUL1, S_FMUL2, S_CMUL, S_SMUL: begin
        u_op = '{start: !run_r, is_div: 1'b0, steps: 7'd0};
        case (state_r)
          S_PMUL:  begin u_a = 64'(abse_r);     u_b = 24'(gp_r);   end
          S_DMUL:  begin u_a = 64'(absdm);      u_b = 24'(gd_r);   end
          S_TMUL:  begin u_a = 64'(abse_r);     u_b = 24'(tick_r); end
          S_IMUL:  begin u_a = 64'(tent_mag);   u_b = 24'(gi_r);   end
          S_FMUL1: begin u_a = 64'(den - n_cl); u_b = 24'(pl);     end
          S_FMUL2: begin u_a = 64'(n_cl);       u_b = 24'(ph);     end
          S_CMUL:  begin u_a = 64'(base_r);     u_b = 24'(fsel);   end
          default: begin u_a = 64'(ff_r);       u_b = MUL_SEED;    end
        endcase
        if (!run_r) run_nxt = 1'b1;
        else if (u_done) begin
          run_nxt = 1'b0;
          case (state_r)
            S_PMUL:  state_nxt = S_PDIV;
            S_DMUL:  state_nxt = S_DDIV;
            S_TMUL: begin
              dlt = $signed({{(ACC_W-30){1'b0}}, u_res[31:0]});
              if (e_r[16]) dlt = -dlt;
              tsum = $signed({{2{acc_r[ACC_W-1]}}, acc_r}) + dlt;
              if (!tsum[ACC_W+1] && tsum[ACC_W:ACC_W-1] != 2'b00)
                tent_nxt = {1'b0, {(ACC_W-1){1'b1}}};
              else if (tsum[ACC_W+1] && tsum[ACC_W:ACC_W-1] != 2'b11)
                tent_nxt = {1'b1, {(ACC_W-1){1'b0}}};
              else
                tent_nxt = tsum[ACC_W-1:0];
              state_nxt = S_IMUL;
            end
            S_IMUL:  state_nxt = S_IDIV;
            S_FMUL1: begin
              ff2_nxt   = u_res[22:0];
              state_nxt = S_FMUL2;
            end
            S_FMUL2: begin
              ff2_nxt   = ff2_r + u_res[22:0];
              state_nxt = S_FDIV;
            end
            S_CMUL:  state_nxt = S_CDIV;
            default: state_nxt = S_SDIV;
          endcase
        end
      end
      S_PDIV, S_DDIV, S_IDIV, S_FFLAT, S_FDIV, S_CDIV, S_SDIV: begin
        case (state_r)
          S_PDIV: begin
            u_op = '{start: !run_r, is_div: 1'b1, steps: W_PD};
            u_a  = u_res << 38;
            u_b  = DIV_MILLI;
          end
          S_DDIV: begin
            u_op = '{start: !run_r, is_div: 1'b1, steps: W_PD};
            u_a  = u_res << 38;
            u_b  = 24'(tick_r);
          end
          S_IDIV: begin
            u_op = '{start: !run_r, is_div: 1'b1, steps: W_I};
            u_a  = u_res << 7;
            u_b  = DIV_I;
          end
          S_FFLAT: begin
            u_op = '{start: !run_r, is_div: 1'b1, steps: W_PCT};
            u_a  = 64'(pl) << 57;
            u_b  = DIV_PCT;
          end
          S_FDIV: begin
            u_op = '{start: !run_r, is_div: 1'b1, steps: W_FF};
            u_a  = 64'(ff2_r) << 41;
            u_b  = ff_dsor;
          end
          S_CDIV: begin
            u_op = '{start: !run_r, is_div: 1'b1, steps: W_PCT};
            u_a  = u_res << 41;
            u_b  = DIV_PCT;
          end
          default: begin
            u_op = '{start: !run_r, is_div: 1'b1, steps: W_SEED};
            u_a  = u_res << 28;
            u_b  = {2'b0, gi_r, 12'b0};
          end
        endcase
        if (!run_r) run_nxt = 1'b1;
        else if (u_done) begin
          run_nxt = 1'b0;
          case (state_r)
            S_PDIV: begin
              term_s  = $signed({{(SUM_W-29){1'b0}}, u_res[28:0]});
              sum_nxt = e_r[16] ? -term_s : term_s;
              state_nxt = hist_r ? S_DMUL : S_TMUL;
            end
            S_DDIV: begin
              term_s  = $signed({{(SUM_W-38){1'b0}}, u_res[37:0]});
              sum_nxt = dm_pos ? sum_r - term_s : sum_r + term_s;
              state_nxt = S_TMUL;
            end
            S_IDIV: begin
              icap    = (u_res > 64'(I_CAP)) ? I_CAP : u_res[40:0];
              term_s  = $signed({{(SUM_W-41){1'b0}}, icap});
              sum_nxt = tent_r[ACC_W-1] ? sum_r - term_s : sum_r + term_s;
              state_nxt = mode_r[MODE_FF] ? ff_state : ceil_state;
            end
            S_FFLAT, S_FDIV: begin
              if (cmd_r == CMD_COMPUTE) begin
                sum_nxt   = sum_r + $signed({{(SUM_W-17){1'b0}}, ffl});
                state_nxt = ceil_state;
              end else begin
                ff_nxt    = ffl;
                state_nxt = S_SMUL;
              end
            end
            S_CDIV: begin
              hi_nxt    = u_res[16:0];
              state_nxt = S_FIN;
            end
            default: begin
              seed_nxt  = u_res[ACC_W-1:0];
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          duty_nxt      = '0;
          if (cmd_r == CMD_COMPUTE && tick_r != 16'd0) begin
            if (sum_r > $signed({{(SUM_W-17){1'b0}}, hi_use})) begin
              duty_nxt   = hi_use;
              status_nxt = STAT_HIGH;
            end else if (sum_r < $signed({{(SUM_W-17){1'b0}}, lo_r})) begin
              duty_nxt   = lo_r;
              status_nxt = STAT_LOW;
            end else begin
              duty_nxt   = sum_r[16:0];
              status_nxt = STAT_NORMAL;
            end
            if (!((status_nxt == STAT_HIGH && !e_r[16] && e_r != 17'sd0) ||
                  (status_nxt == STAT_LOW && e_r[16])))
              acc_nxt = tent_r;
            last_nxt = m_r;
            hist_nxt = 1'b1;
          end else if (cmd_r == CMD_COMPUTE) begin
            acc_nxt    = '0;
            last_nxt   = '0;
            hist_nxt   = 1'b0;
            status_nxt = STAT_REJECT;
          end else if (cmd_r == CMD_BUMPLESS) begin
            acc_nxt    = seed_r;
            last_nxt   = '0;
            hist_nxt   = 1'b0;
            status_nxt = STAT_RESET;
          end else begin
            acc_nxt    = '0;
            last_nxt   = '0;
            hist_nxt   = 1'b0;
            status_nxt = STAT_RESET;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_r       <= 1'b0;
      acc_r       <= '0;
      last_r      <= '0;
      hist_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      acc_r       <= acc_nxt;
      last_r      <= last_nxt;
      hist_r      <= hist_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    sp_r     <= sp_nxt;
    m_r      <= m_nxt;
    tick_r   <= tick_nxt;
    e_r      <= e_nxt;
    abse_r   <= abse_nxt;
    sum_r    <= sum_nxt;
    lo_r     <= lo_nxt;
    base_r   <= base_nxt;
    hi_r     <= hi_nxt;
    ff_r     <= ff_nxt;
    ff2_r    <= ff2_nxt;
    tent_r   <= tent_nxt;
    seed_r   <= seed_nxt;
    duty_r   <= duty_nxt;
    status_r <= status_nxt;
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_duty   = duty_r;
  assign out_status = status_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("no work started after an accepted beat");

  a_idle_no_op: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !run_r)
    else $error("serial op pending while idle");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result beat loaded outside the finish step");
`endif

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the heater PID controller. A predictor computes the
// duty and status of every accepted item and a scoreboard compares each
// result beat against the oldest prediction. The run goes through directed
// corner items and several register settings with random traffic, random
// sender bursts, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import pidh_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 400;
  localparam int N_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 160;

  class duty_scoreboard;
    longint unsigned gp, gi, gd, limits, mode, ff_pts, bands, factors;
    longint acc;
    longint last_m;
    bit hist_ok;
    logic [16:0] duty_q[$];
    logic [2:0] status_q[$];
    int n_err;

    function new();
      gp = 0; gi = 0; gd = 0; limits = 25600; mode = 0;
      ff_pts = 819300; bands = 206326284338; factors = 27054912100;
      acc = 0; last_m = 0; hist_ok = 0; n_err = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [47:0] v);
      case (idx)
        REG_GAIN_P:  gp = v[9:0];
        REG_GAIN_I:  gi = v[9:0];
        REG_GAIN_D:  gd = v[9:0];
        REG_LIMITS:  limits = v[15:0];
        REG_MODE:    mode = v[1:0];
        REG_FF_PTS:  ff_pts = v[37:0];
        REG_BANDS:   bands = v[47:0];
        REG_FACTORS: factors = v[34:0];
        default: ;
      endcase
    endfunction

    function longint pct_q16(longint unsigned p);
      if (p > 100) p = 100;
      return longint'(p * 65536 / 100);
    endfunction

    function longint acc_sat_add(longint a, longint dl);
      longint mx, mn;
      mx = (longint'(1) <<< (ACC_W - 1)) - 1;
      mn = -mx - 1;
      if (dl > 0 && a > mx - dl) return mx;
      if (dl < 0 && a < mn - dl) return mn;
      return a + dl;
    endfunction

    function longint feedforward(longint sp);
      longint tl, th, pl, ph, fwd, den, n;
      tl = ff_pts & 12'hFFF;
      th = (ff_pts >> 12) & 12'hFFF;
      pl = (ff_pts >> 24) & 7'h7F;
      ph = (ff_pts >> 31) & 7'h7F;
      if (th <= tl) begin
        fwd = pl * 65536 / 100;
      end else begin
        den = (th - tl) * 16;
        n = sp - tl * 16;
        if (n < 0) n = 0;
        if (n > den) n = den;
        fwd = (pl * (den - n) + ph * n) * 65536 / (100 * den);
      end
      if (fwd > pct_q16((limits >> 8) & 8'hFF)) fwd = pct_q16((limits >> 8) & 8'hFF);
      return fwd;
    endfunction

    function longint ceiling_for(longint abs_e, longint base);
      longint thr[4];
      longint unsigned f;
      if (mode[MODE_ADAPT] == 0) return base;
      for (int b = 0; b < 4; b++) thr[b] = longint'((bands >> (12 * b)) & 12'hFFF) * 16;
      if (abs_e >= thr[0]) return base;
      if (abs_e >= thr[1]) f = factors & 7'h7F;
      else if (abs_e >= thr[2]) f = (factors >> 7) & 7'h7F;
      else if (abs_e >= thr[3]) f = (factors >> 14) & 7'h7F;
      else f = (factors >> 21) & 7'h7F;
      if (f > 100) f = 100;
      return base * longint'(f) / 100;
    endfunction

    function longint integral_term(longint a);
      longint unsigned mag, kk, q, r, t, cap;
      cap = longint'(1) << 40;
      mag = a < 0 ? -a : a;
      kk = gi * 4096;
      q = mag / 1000000;
      r = mag % 1000000;
      if (kk != 0 && q > cap / kk) begin
        t = cap;
      end else begin
        t = q * kk + (r * kk) / 1000000;
        if (t > cap) t = cap;
      end
      return a < 0 ? -longint'(t) : longint'(t);
    endfunction

    function void note_input(logic [1:0] cmd, logic signed [15:0] sp_in,
                             logic signed [15:0] m_in, logic [15:0] tick_in);
      longint sp, m, tick, e, abs_e, p, d, fwd, tent, u, hi, lo, duty, dm, seed;
      logic [2:0] st;
      sp = sp_in; m = m_in; tick = tick_in;
      d = 0; fwd = 0; st = STAT_NORMAL;
      if (cmd != CMD_COMPUTE) begin
        if (cmd == CMD_BUMPLESS) begin
          seed = 0;
          last_m = 0;
          hist_ok = 0;
          if (mode[MODE_FF] == 0 && gi != 0) begin
            seed = feedforward(sp) * 1000000 / (longint'(gi) * 4096);
            if (seed > (longint'(1) <<< (ACC_W - 1)) - 1) seed = (longint'(1) <<< (ACC_W - 1)) - 1;
          end
          acc = seed;
        end else begin
          acc = 0; last_m = 0; hist_ok = 0;
        end
        duty_q.push_back('0);
        status_q.push_back(STAT_RESET);
        return;
      end
      if (tick == 0) begin
        acc = 0; last_m = 0; hist_ok = 0;
        duty_q.push_back('0);
        status_q.push_back(STAT_REJECT);
        return;
      end
      e = sp - m;
      abs_e = e < 0 ? -e : e;
      p = longint'(gp) * abs_e * 4096 / 1000;
      if (e < 0) p = -p;
      if (hist_ok) begin
        dm = m - last_m;
        d = longint'(gd) * (dm < 0 ? -dm : dm) * 4096 / tick;
        if (dm > 0) d = -d;
      end
      tent = acc_sat_add(acc, e * tick);
      if (mode[MODE_FF]) fwd = feedforward(sp);
      u = p + integral_term(tent) + d + fwd;
      hi = ceiling_for(abs_e, pct_q16((limits >> 8) & 8'hFF));
      lo = pct_q16(limits & 8'hFF);
      duty = u;
      if (duty > hi) begin
        duty = hi; st = STAT_HIGH;
      end else if (duty < lo) begin
        duty = lo; st = STAT_LOW;
      end
      if (!((st == STAT_HIGH && e > 0) || (st == STAT_LOW && e < 0))) acc = tent;
      last_m = m;
      hist_ok = 1;
      duty_q.push_back(duty[16:0]);
      status_q.push_back(st);
    endfunction

    function void fail_note(string msg);
      n_err++;
      if (n_err <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_result(logic [16:0] duty, logic [2:0] st);
      logic [16:0] ed;
      logic [2:0] es;
      if (duty_q.size() == 0) begin
        fail_note($sformatf("unexpected beat duty %0d status %0d", duty, st));
        return;
      end
      ed = duty_q.pop_front();
      es = status_q.pop_front();
      if (duty !== ed) fail_note($sformatf("duty expected %0d got %0d", ed, duty));
      if (st !== es) fail_note($sformatf("status expected %0d got %0d", es, st));
    endfunction

    function int pending();
      return duty_q.size();
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_command;
  logic signed [15:0] in_setpoint, in_measured_temp;
  logic [15:0] in_tick_ms;
  logic out_valid, out_stall;
  logic [16:0] out_duty;
  logic [2:0] out_status;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [47:0] cfg_data;

  duty_scoreboard sb;
  int cycles;
  int stall_mode;
  bit hold_go, hold_done;
  int hold_cnt;

  pid_heater_controller dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    in_valid = 0; in_command = CMD_COMPUTE; in_setpoint = 0;
    in_measured_temp = 0; in_tick_ms = 0;
    out_stall = 0;
    cfg_valid = 0; cfg_index = REG_GAIN_P; cfg_data = 0;
    stall_mode = 0; hold_go = 0; hold_done = 0; hold_cnt = 0; cycles = 0;
    sb = new();
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** pid_heater_controller: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_duty, out_status);
  end

  // receiver stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_go && !hold_done && hold_cnt == 0) begin
      hold_cnt <= 3000;
      hold_done <= 1;
      out_stall <= 1;
    end else if (hold_cnt > 1) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1;
    end else begin
      hold_cnt <= 0;
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= ($urandom_range(0, 99) < 75);
        default: out_stall <= (cycles % 17) < 8;
      endcase
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [47:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic send_item(logic [1:0] cmd, logic signed [15:0] sp,
                           logic signed [15:0] m, logic [15:0] tick);
    in_valid <= 1;
    in_command <= cmd;
    in_setpoint <= sp;
    in_measured_temp <= m;
    in_tick_ms <= tick;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(cmd, sp, m, tick);
  endtask

  task automatic go_idle(int n);
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic logic [9:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return 10'd0;
      1: return 10'h3FF;
      2: return 10'd1000;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic write_all_regs(int ph);
    logic [47:0] lim, ffp;
    lim = 48'({8'($urandom_range(50, 100)), 8'($urandom_range(0, 40))});
    if (ph % 4 == 3) lim = rand48();
    if (ph == 1) lim = {8'd255, 8'd255};
    if (ph == 2) lim = {8'd20, 8'd80};
    ffp = 48'({7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
               12'($urandom_range(100, 300)), 12'($urandom_range(0, 99))});
    if (ph % 3 == 2) ffp = rand48();
    write_reg(REG_GAIN_P, ph == 0 ? 48'd0 : (ph == 1 ? 48'h3FF : 48'(pick_gain())));
    write_reg(REG_GAIN_I, ph == 0 ? 48'd0 : (ph == 1 ? 48'h3FF : 48'(pick_gain())));
    write_reg(REG_GAIN_D, ph == 0 ? 48'd0 : (ph == 1 ? 48'h3FF : 48'(pick_gain())));
    write_reg(REG_LIMITS, lim);
    write_reg(REG_MODE, 48'(ph % 4));
    write_reg(REG_FF_PTS, ffp);
    write_reg(REG_BANDS, ph % 2 ? rand48() :
              {12'($urandom_range(0, 5)), 12'($urandom_range(5, 20)),
               12'($urandom_range(20, 60)), 12'($urandom_range(60, 200))});
    write_reg(REG_FACTORS, ph == 1 ? 48'hFFFFFFFFFFFF : rand48());
    cfg_valid <= 0;
  endtask

  task automatic random_item();
    logic [1:0] cmd;
    logic signed [15:0] sp, m;
    logic [15:0] tick;
    int r;
    r = $urandom_range(0, 99);
    cmd = r < 84 ? CMD_COMPUTE : r < 91 ? CMD_RESET : r < 97 ? CMD_BUMPLESS : CMD_SPARE;
    if ($urandom_range(0, 4) == 0) begin
      sp = 16'($urandom());
      m = 16'($urandom());
    end else begin
      sp = 16'($urandom_range(0, 6000));
      m = sp + 16'($urandom_range(0, 1200)) - 16'sd600;
    end
    r = $urandom_range(0, 99);
    tick = r < 3 ? 16'd0 : r < 8 ? 16'hFFFF : r < 15 ? 16'($urandom()) :
           16'($urandom_range(1, 2000));
    send_item(cmd, sp, m, tick);
  endtask

  initial begin
    int left, burst;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    write_reg(REG_GAIN_P, 48'd500);
    write_reg(REG_GAIN_I, 48'd200);
    write_reg(REG_GAIN_D, 48'd100);
    write_reg(REG_LIMITS, {8'd90, 8'd10});
    write_reg(REG_MODE, 48'd1);
    cfg_valid <= 0;
    send_item(CMD_COMPUTE, 16'sd1600, 16'sd1500, 16'd100);
    send_item(CMD_COMPUTE, 16'sd1600, 16'sd1550, 16'd100);
    send_item(CMD_COMPUTE, 16'sh7FFF, 16'sh8000, 16'hFFFF);
    send_item(CMD_COMPUTE, 16'sh8000, 16'sh7FFF, 16'd1);
    send_item(CMD_COMPUTE, 16'sh8000, 16'sh7FFF, 16'hFFFF);
    send_item(CMD_COMPUTE, 16'sd0, 16'sd0, 16'd0);
    send_item(CMD_COMPUTE, 16'sd0, 16'sd0, 16'd1);
    send_item(CMD_RESET, 16'sd0, 16'sd0, 16'd5);
    send_item(CMD_COMPUTE, 16'sd3200, 16'sd3000, 16'd50);
    send_item(CMD_BUMPLESS, 16'sd3200, 16'sd0, 16'd0);
    send_item(CMD_COMPUTE, 16'sd3200, 16'sd3180, 16'd50);
    send_item(CMD_SPARE, 16'sd100, 16'sd100, 16'd10);
    send_item(CMD_COMPUTE, 16'sd800, 16'sd800, 16'd20);
    send_item(CMD_COMPUTE, 16'sd800, 16'sd900, 16'd20);
    send_item(CMD_COMPUTE, 16'sd800, 16'sd700, 16'd20);
    wait_drained();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_all_regs(ph);
      stall_mode = ph % 4;
      if (ph == 2) hold_go = 1;
      left = ITEMS_PER_PHASE;
      while (left > 0) begin
        burst = $urandom_range(1, 12);
        while (burst > 0 && left > 0) begin
          random_item();
          burst--;
          left--;
        end
        if (ph % 3 != 0 && $urandom_range(0, 2) != 0) go_idle($urandom_range(1, 30));
      end
      wait_drained();
    end

    if (sb.pending() != 0) sb.fail_note("predictions left over at end");
    if (sb.n_err == 0) begin
      $display("** pid_heater_controller: PASSED **");
    end else begin
      $display("** pid_heater_controller: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
src/pidh_pkg.sv
src/pidh_serial.sv
src/pid_heater_controller.sv
tb/testbench.sv
